// ===== rtl/ikarm_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the
// two-link arm inverse kinematics block. No dependencies.
`default_nettype none
package ikarm_pkg;

   localparam int FRAC_BITS = 16;
   localparam int ITERS     = FRAC_BITS + 4;
   localparam int IDX_W     = 5;
   localparam int ANG_W     = 40;          // internal angle, 0.0001 deg with 16 fraction bits
   localparam int XY_W      = 36;          // CORDIC x/y datapath
   localparam int SWP_W     = 22;          // sweep index, 0.0001 deg
   localparam int ERR_W     = 40;
   localparam int MUL_W     = 28;          // shared multiplier operand
   localparam int PROD_W    = 2 * MUL_W;
   localparam int NUM_W     = 34;
   localparam int DEN_W     = 27;

   // configuration register indexes
   localparam logic [1:0] REG_UPPER = 2'd0;
   localparam logic [1:0] REG_LOWER = 2'd1;
   localparam logic [1:0] REG_STEP  = 2'd2;

   localparam longint ONE          = longint'(1) << FRAC_BITS;
   localparam longint SWEEP_LIMIT  = 900000;
   localparam longint HALF_TURN    = 1800000;
   localparam longint QUARTER_TURN = 900000;
   localparam longint ERR_BOUND    = 1000000;
   localparam longint GAIN_Q32     = 64'd2608131496;
   localparam longint GAIN = (GAIN_Q32 + (longint'(1) << (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);

   localparam logic signed [ANG_W-1:0] HALF_Q    = ANG_W'(HALF_TURN * ONE);
   localparam logic signed [ANG_W-1:0] TURN_Q    = ANG_W'(2 * HALF_TURN * ONE);
   localparam logic signed [ANG_W-1:0] QUARTER_Q = ANG_W'(QUARTER_TURN * ONE);
   localparam logic signed [ERR_W-1:0] ERR_INIT  = ERR_W'(ERR_BOUND * ONE);
   localparam logic signed [SWP_W-1:0] SWP_START = -SWP_W'(SWEEP_LIMIT);
   localparam logic signed [SWP_W-1:0] SWP_END   = SWP_W'(SWEEP_LIMIT);
   localparam logic signed [MUL_W-1:0] GAIN_OP   = MUL_W'(GAIN);

   typedef struct packed {
      logic                    start;
      logic                    vec;    // 1: vectoring, 0: rotation
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [ANG_W-1:0] z;
   } cordic_req_type;

   // atan(2^-i) in internal angle format
   function automatic logic signed [ANG_W-1:0] atan_q(input logic [IDX_W-1:0] i);
      logic signed [ANG_W-1:0] v;
      case (i)
         5'd0:    v = 40'sd29491200000;
         5'd1:    v = 40'sd17409671939;
         5'd2:    v = 40'sd9198792519;
         5'd3:    v = 40'sd4669450714;
         5'd4:    v = 40'sd2343786496;
         5'd5:    v = 40'sd1173035816;
         5'd6:    v = 40'sd586661043;
         5'd7:    v = 40'sd293348423;
         5'd8:    v = 40'sd146676450;
         5'd9:    v = 40'sd73338505;
         5'd10:   v = 40'sd36669287;
         5'd11:   v = 40'sd18334648;
         5'd12:   v = 40'sd9167325;
         5'd13:   v = 40'sd4583662;
         5'd14:   v = 40'sd2291831;
         5'd15:   v = 40'sd1145916;
         5'd16:   v = 40'sd572958;
         5'd17:   v = 40'sd286479;
         5'd18:   v = 40'sd143239;
         5'd19:   v = 40'sd71620;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ikarm_cordic.sv =====
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// Depends on ikarm_pkg (types, iteration count, arctangent table).
`default_nettype none
module ikarm_cordic import ikarm_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cordic_req_type          req,
   output logic                         done,
   output logic signed [XY_W-1:0]       x_out,
   output logic signed [XY_W-1:0]       y_out,
   output logic signed [ANG_W-1:0]      z_out
);

   logic signed [XY_W-1:0]  x_ff, y_ff, x_in, y_in, xs, ys;
   logic signed [ANG_W-1:0] z_ff, z_in, at;
   logic [IDX_W-1:0]        cnt_ff;
   logic                    busy_ff, done_ff, vec_ff, dir;

   always_comb begin
      xs  = x_ff >>> cnt_ff;
      ys  = y_ff >>> cnt_ff;
      at  = atan_q(cnt_ff);
      // vectoring drives y toward zero, rotation drives z toward zero
      dir = vec_ff ? y_ff[XY_W-1] : ~z_ff[ANG_W-1];
      if (dir) begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
         z_in = z_ff - at;
      end else begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
         z_in = z_ff + at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == IDX_W'(ITERS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         x_ff   <= req.x;
         y_ff   <= req.y;
         z_ff   <= req.z;
         vec_ff <= req.vec;
      end else if (busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule
`default_nettype wire

// ===== rtl/ikarm_isqrt.sv =====
// Bit-pair integer square root, one result bit per cycle.
// Depends on ikarm_pkg only through the shared import convention.
`default_nettype none
module ikarm_isqrt import ikarm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] value,
   output logic             done,
   output logic [31:0]      root
);

   logic [63:0] v_ff, res_ff, bit_ff, trial;
   logic [4:0]  cnt_ff;
   logic        busy_ff, done_ff;

   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= value;
         res_ff <= '0;
         bit_ff <= 64'd1 << 62;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_ff   <= v_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule
`default_nettype wire

// ===== rtl/two_link_arm_inverse_kinematics_top.sv =====
// Two-link arm inverse kinematics: one shared CORDIC, a square root unit and a
// shared multiplier under a sequencer. Depends on ikarm_pkg, ikarm_cordic, ikarm_isqrt.
//
// Usage:
//  - Input channel req_*: target x, y, z; a transfer happens when req_valid is high
//    and req_stall is low. req_stall is high while an item is in work.
//  - Result channel rsp_*: shoulder and elbow angles (0.0001 deg), height, unreachable.
//    The result sits in an output register; the next item is taken while it waits.
//  - csr_*: write link lengths (index 0, 1) and sweep step (index 2) while idle.
//  - Sequence: the products, the root, the elbow vectoring, then for each sweep angle
//    two CORDIC rotations plus launch and error compare. Sweep angles =
//    floor(1800000 / step) + 1, so the default step of 1000 gives 1801 angles.
//    An unreachable point goes from the products straight to the output state.
//  - Reset (synchronous) returns the registers to 100, 100, 1000 and empties
//    the output register. A stalled receiver holds the result; a finished item
//    waits in the output state until the register frees up.
`default_nettype none
module two_link_arm_inverse_kinematics_top import ikarm_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_target_x,
   input  wire logic signed [15:0] req_target_y,
   input  wire logic signed [15:0] req_target_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [20:0]      rsp_shoulder_angle,
   output logic [20:0]             rsp_elbow_angle,
   output logic signed [15:0]      rsp_height,
   output logic                    rsp_unreachable,
   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [19:0]        csr_write_data
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MUL   = 4'd1;
   localparam logic [3:0] S_CHECK = 4'd2;
   localparam logic [3:0] S_SQRT  = 4'd3;
   localparam logic [3:0] S_VEC   = 4'd4;
   localparam logic [3:0] S_L1    = 4'd5;
   localparam logic [3:0] S_ROT1  = 4'd6;
   localparam logic [3:0] S_ROT2  = 4'd7;
   localparam logic [3:0] S_ERR   = 4'd8;
   localparam logic [3:0] S_CMP   = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;

   logic [11:0] upper_ff, lower_ff;
   logic [19:0] step_ff;
   logic [3:0]  state_ff, state_in;
   logic [3:0]  mul_idx_ff;

   logic signed [15:0]       x_ff, y_ff, z_ff;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [NUM_W-1:0]  num_ff;
   logic [DEN_W-1:0]         den_ff;
   logic signed [PROD_W-1:0] nsq_ff, dsq_ff;
   logic signed [XY_W-1:0]   g1_ff, g2_ff;
   logic signed [ANG_W-1:0]  elbow_q_ff, elbow_clamp;
   logic signed [SWP_W-1:0]  ang_i_ff, i_next, shoulder_ff;
   logic signed [ERR_W-1:0]  best_ff, adx_ff, ady_ff, err_sum, dx, dy;
   logic signed [XY_W-1:0]   c1_ff, s1_ff, c_res, s_res;
   logic                     neg_ff, unreach_ff, reachable;
   logic                     rsp_valid_ff;
   logic signed [20:0]       rsp_shoulder_ff;
   logic [20:0]              rsp_elbow_ff;
   logic signed [15:0]       rsp_height_ff;
   logic                     rsp_unreach_ff;

   logic                     sq_done;
   logic [31:0]              sq_root;
   logic [63:0]              sq_value;
   logic signed [PROD_W-1:0] sq_diff;
   cordic_req_type           creq;
   logic                     c_done;
   logic signed [XY_W-1:0]   c_x, c_y;
   logic signed [ANG_W-1:0]  c_z, ang_raw, ang_wrap, ang_fold;
   logic                     neg_in;
   logic signed [XY_W-1:0]   vx;
   logic signed [ERR_W-1:0]  x_one, y_one;
   logic [19:0]              step_eff;
   logic                     out_free;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= 12'd100;
         lower_ff <= 12'd100;
         step_ff  <= 20'd1000;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_UPPER: upper_ff <= csr_write_data[11:0];
            REG_LOWER: lower_ff <= csr_write_data[11:0];
            REG_STEP:  step_ff  <= csr_write_data;
            default:   ;
         endcase
      end
   end

   // shared multiplier operand select
   always_comb begin
      case (mul_idx_ff)
         4'd0: begin mul_a = MUL_W'(x_ff); mul_b = MUL_W'(x_ff); end
         4'd1: begin mul_a = MUL_W'(y_ff); mul_b = MUL_W'(y_ff); end
         4'd2: begin
            mul_a = MUL_W'(signed'({1'b0, upper_ff}));
            mul_b = MUL_W'(signed'({1'b0, upper_ff}));
         end
         4'd3: begin
            mul_a = MUL_W'(signed'({1'b0, lower_ff}));
            mul_b = MUL_W'(signed'({1'b0, lower_ff}));
         end
         4'd4: begin
            mul_a = MUL_W'(signed'({1'b0, upper_ff}));
            mul_b = MUL_W'(signed'({1'b0, lower_ff}));
         end
         4'd5: begin mul_a = GAIN_OP; mul_b = MUL_W'(signed'({1'b0, upper_ff})); end
         4'd6: begin mul_a = GAIN_OP; mul_b = MUL_W'(signed'({1'b0, lower_ff})); end
         4'd7: begin mul_a = num_ff[MUL_W-1:0]; mul_b = num_ff[MUL_W-1:0]; end
         4'd8: begin
            mul_a = MUL_W'(signed'({1'b0, den_ff}));
            mul_b = MUL_W'(signed'({1'b0, den_ff}));
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign reachable = (den_ff != '0) && (num_ff <= NUM_W'(signed'({1'b0, den_ff})))
                      && (num_ff >= -NUM_W'(signed'({1'b0, den_ff})));
   assign sq_diff   = dsq_ff - nsq_ff;
   assign sq_value  = {sq_diff[51:0], 12'd0};

   ikarm_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_CHECK && reachable),
      .value (sq_value),
      .done  (sq_done),
      .root  (sq_root)
   );

   // rotation angle: wrap to one turn, then fold into [-90, 90] deg
   always_comb begin
      ang_raw = {{(ANG_W-SWP_W-FRAC_BITS){ang_i_ff[SWP_W-1]}}, ang_i_ff, {FRAC_BITS{1'b0}}};
      if (state_ff == S_ROT1)
         ang_raw = ang_raw + elbow_q_ff;
      ang_wrap = ang_raw;
      if (ang_raw > HALF_Q)
         ang_wrap = ang_raw - TURN_Q;
      else if (ang_raw < -HALF_Q)
         ang_wrap = ang_raw + TURN_Q;
      neg_in   = 1'b0;
      ang_fold = ang_wrap;
      if (ang_wrap > QUARTER_Q) begin
         ang_fold = ang_wrap - HALF_Q;
         neg_in   = 1'b1;
      end else if (ang_wrap < -QUARTER_Q) begin
         ang_fold = ang_wrap + HALF_Q;
         neg_in   = 1'b1;
      end
   end

   always_comb begin
      vx = {num_ff[XY_W-7:0], 6'd0};
      creq.start = 1'b0;
      creq.vec   = 1'b0;
      creq.x     = '0;
      creq.y     = '0;
      creq.z     = ang_fold;
      if (state_ff == S_SQRT) begin
         creq.start = sq_done;
         creq.vec   = 1'b1;
         if (vx < 0) begin
            creq.x = XY_W'({1'b0, sq_root});
            creq.y = -vx;
            creq.z = QUARTER_Q;
         end else begin
            creq.x = vx;
            creq.y = XY_W'({1'b0, sq_root});
            creq.z = '0;
         end
      end else if (state_ff == S_L1) begin
         creq.start = 1'b1;
         creq.x     = g1_ff;
      end else if (state_ff == S_ROT1) begin
         creq.start = c_done;
         creq.x     = g2_ff;
      end
   end

   ikarm_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .req   (creq),
      .done  (c_done),
      .x_out (c_x),
      .y_out (c_y),
      .z_out (c_z)
   );

   assign c_res = neg_ff ? -c_x : c_x;
   assign s_res = neg_ff ? -c_y : c_y;

   always_comb begin
      elbow_clamp = c_z;
      if (c_z < 0)
         elbow_clamp = '0;
      else if (c_z > HALF_Q)
         elbow_clamp = HALF_Q;
   end

   assign x_one    = ERR_W'(x_ff) <<< FRAC_BITS;
   assign y_one    = ERR_W'(y_ff) <<< FRAC_BITS;
   assign dx       = ERR_W'(c1_ff) + ERR_W'(c_res) - x_one;
   assign dy       = ERR_W'(s1_ff) + ERR_W'(s_res) - y_one;
   assign err_sum  = adx_ff + ady_ff;
   assign step_eff = (step_ff == '0) ? 20'd1 : step_ff;
   assign i_next   = ang_i_ff + SWP_W'(signed'({1'b0, step_eff}));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_MUL;
         S_MUL:   if (mul_idx_ff == 4'd9) state_in = S_CHECK;
         S_CHECK: state_in = reachable ? S_SQRT : S_OUT;
         S_SQRT:  if (sq_done) state_in = S_VEC;
         S_VEC:   if (c_done) state_in = S_L1;
         S_L1:    state_in = S_ROT1;
         S_ROT1:  if (c_done) state_in = S_ROT2;
         S_ROT2:  if (c_done) state_in = S_ERR;
         S_ERR:   state_in = S_CMP;
         S_CMP:   state_in = (i_next > SWP_END) ? S_OUT : S_L1;
         S_OUT:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mul_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_IDLE)
            mul_idx_ff <= '0;
         else if (state_ff == S_MUL)
            mul_idx_ff <= mul_idx_ff + 1'b1;
         if (state_ff == S_OUT && out_free)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (state_ff == S_IDLE && req_valid) begin
         x_ff <= req_target_x;
         y_ff <= req_target_y;
         z_ff <= req_target_z;
      end
      if (state_ff == S_MUL) begin
         // consume the product launched in the previous cycle
         case (mul_idx_ff)
            4'd1: num_ff <= NUM_W'(prod_ff);
            4'd2: num_ff <= num_ff + NUM_W'(prod_ff);
            4'd3: num_ff <= num_ff - NUM_W'(prod_ff);
            4'd4: num_ff <= num_ff - NUM_W'(prod_ff);
            4'd5: den_ff <= {prod_ff[DEN_W-2:0], 1'b0};
            4'd6: g1_ff  <= XY_W'(prod_ff);
            4'd7: g2_ff  <= XY_W'(prod_ff);
            4'd8: nsq_ff <= prod_ff;
            4'd9: dsq_ff <= prod_ff;
            default: ;
         endcase
      end
      if (state_ff == S_CHECK) begin
         unreach_ff  <= !reachable;
         ang_i_ff    <= SWP_START;
         best_ff     <= ERR_INIT;
         shoulder_ff <= '0;
         elbow_q_ff  <= '0;
      end
      if (state_ff == S_VEC && c_done)
         elbow_q_ff <= elbow_clamp;
      if (creq.start && !creq.vec)
         neg_ff <= neg_in;
      if (state_ff == S_ROT1 && c_done) begin
         c1_ff <= c_res;
         s1_ff <= s_res;
      end
      if (state_ff == S_ERR) begin
         adx_ff <= dx[ERR_W-1] ? -dx : dx;
         ady_ff <= dy[ERR_W-1] ? -dy : dy;
      end
      if (state_ff == S_CMP) begin
         if (err_sum < best_ff) begin
            best_ff     <= err_sum;
            shoulder_ff <= ang_i_ff;
         end
         ang_i_ff <= i_next;
      end
      if (state_ff == S_OUT && out_free) begin
         rsp_shoulder_ff <= unreach_ff ? '0 : shoulder_ff[20:0];
         rsp_elbow_ff    <= unreach_ff ? '0 : elbow_q_ff[FRAC_BITS+20:FRAC_BITS];
         rsp_height_ff   <= z_ff;
         rsp_unreach_ff  <= unreach_ff;
      end
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_shoulder_angle = rsp_shoulder_ff;
   assign rsp_elbow_angle    = rsp_elbow_ff;
   assign rsp_height         = rsp_height_ff;
   assign rsp_unreachable    = rsp_unreach_ff;

endmodule
`default_nettype wire
